[rtl/packet_buffer_start_time_scheduler_core_defines.svh]
// Assertion macros shared by the packet buffer scheduler RTL.
`ifndef PACKET_BUFFER_START_TIME_SCHEDULER_CORE_DEFINES_SVH
`define PACKET_BUFFER_START_TIME_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PBST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define PBST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pbst_pkg.sv]
// Types and constants shared by the packet buffer scheduler modules.
package pbst_pkg;

    localparam int DEPTH_DEF     = 1024;
    localparam int TIME_BITS_DEF = 32;

    localparam int CFG_W     = 11;
    localparam int ARR_W     = 32;
    localparam int PT_W      = 16;
    localparam int START_W   = 32;
    localparam int S_DATA_W  = 48;
    localparam int M_DATA_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_FINISH
    } state_t;

    typedef enum logic {
        ALU_LE,
        ALU_ADD_SAT
    } alu_op_t;

    typedef struct packed {
        logic s_ready;
        logic pop;
        logic drop;
        logic load_start;
        logic push;
    } ctrl_t;

endpackage

[rtl/packet_buffer_start_time_scheduler_core.sv]
// Packet buffer scheduler: per packet, expired finish times are popped from the
// FIFO one per cycle (the store has a single read port), then the packet is
// dropped if the buffer is still full, or given a start time and its finish time
// pushed. A packet is taken in the idle state and then scanned, one expired entry
// popped per scan cycle, until no stored entry has expired at its arrival; a dropped
// packet ends there, a kept one passes the start state to form its start and the
// finish state to push its finish. A new packet is accepted only once the last one
// is done, and a drop or a push waits while the output register is busy.
// Results go out through an output register, so a new packet is accepted while
// the previous result is still waiting. s_tready is low during reset.
module packet_buffer_start_time_scheduler_core
    import pbst_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,    // buffer_size
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,        // arrival[31:0], ptime[47:32]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,        // start[31:0]
    output logic                m_tuser         // dropped
);

`include "packet_buffer_start_time_scheduler_core_defines.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > CFG_W) ? OW : CFG_W;
    localparam int BW = (TIME_BITS > PT_W) ? TIME_BITS : PT_W;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [OW-1:0]        occ_reg, occ_next;
    logic [TIME_BITS-1:0] newest_reg, newest_next;
    logic [TIME_BITS-1:0] arr_reg, arr_next;
    logic [PT_W-1:0]      pt_reg, pt_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [CFG_W-1:0]     cap_reg;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_drop_reg, m_drop_next;
    logic [START_W-1:0]   m_start_reg, m_start_next;

    logic [CW-1:0]        cap_eff;
    logic                 full;
    logic                 pop_ok;
    logic                 out_free;
    logic                 accept;

    alu_op_t              alu_op;
    logic [TIME_BITS-1:0] alu_a;
    logic [BW-1:0]        alu_b;
    logic                 alu_le;
    logic [TIME_BITS-1:0] alu_res;
    logic [TIME_BITS-1:0] rd_data;

    pbst_mem #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .AW        (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (ctrl.push),
        .wr_addr (tail_reg),
        .wr_data (alu_res),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    pbst_alu #(
        .TIME_BITS (TIME_BITS)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .le  (alu_le),
        .res (alu_res)
    );

    assign cap_eff  = (CW'(cap_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
    assign full     = CW'(occ_reg) >= cap_eff;
    assign out_free = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    // rd_data holds the head entry here: the read address follows head_next
    assign pop_ok   = (occ_reg != '0) & alu_le;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!pop_ok) begin
                    if (!full) begin
                        state_next = ST_START;
                    end else if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_START: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and shared unit operands
    always_comb begin
        ctrl   = '0;
        alu_op = ALU_LE;
        alu_a  = rd_data;
        alu_b  = BW'(arr_reg);
        case (state_reg)
            ST_IDLE: begin
                ctrl.s_ready = 1'b1;
            end
            ST_SCAN: begin
                ctrl.pop  = pop_ok;
                ctrl.drop = ~pop_ok & full & out_free;
            end
            ST_START: begin
                alu_a           = newest_reg;
                ctrl.load_start = 1'b1;
            end
            ST_FINISH: begin
                alu_op    = ALU_ADD_SAT;
                alu_a     = start_reg;
                alu_b     = BW'(pt_reg);
                ctrl.push = out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        newest_next  = newest_reg;
        arr_next     = arr_reg;
        pt_next      = pt_reg;
        start_next   = start_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_drop_next  = m_drop_reg;
        m_start_next = m_start_reg;

        if (accept) begin
            arr_next = TIME_BITS'(s_tdata[ARR_W-1:0]);
            pt_next  = s_tdata[ARR_W +: PT_W];
        end
        if (ctrl.pop) begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
            occ_next  = occ_reg - OW'(1);
        end
        if (ctrl.drop) begin
            m_valid_next = 1'b1;
            m_drop_next  = 1'b1;
            m_start_next = '0;
        end
        if (ctrl.load_start) begin
            start_next = ((occ_reg == '0) || alu_le) ? arr_reg : newest_reg;
        end
        if (ctrl.push) begin
            tail_next    = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
            occ_next     = occ_reg + OW'(1);
            newest_next  = alu_res;
            m_valid_next = 1'b1;
            m_drop_next  = 1'b0;
            m_start_next = START_W'(start_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            newest_reg  <= '0;
            cap_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            newest_reg  <= newest_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        arr_reg     <= arr_next;
        pt_reg      <= pt_next;
        start_reg   <= start_next;
        m_drop_reg  <= m_drop_next;
        m_start_reg <= m_start_next;
    end

    assign s_tready = ctrl.s_ready & aresetn;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_start_reg;
    assign m_tuser  = m_drop_reg;

    `PBST_ASSERT_NOW(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= OW'(DEPTH), "occupancy above depth")
    `PBST_ASSERT_NOW(a_empty_ptrs, aclk, aresetn, occ_reg == '0, head_reg == tail_reg, "empty buffer with head and tail apart")
    `PBST_ASSERT_NOW(a_drop_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0, "dropped word with nonzero start time")
    `PBST_ASSERT_NEXT(a_push_count, aclk, aresetn, ctrl.push, occ_reg == $past(occ_reg) + OW'(1), "push did not bump occupancy")

endmodule

[rtl/pbst_mem.sv]
// Finish-time store: one write port, one registered read port.
module pbst_mem
    import pbst_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [TIME_BITS-1:0] wr_data,
    input  logic [AW-1:0]        rd_addr,
    output logic [TIME_BITS-1:0] rd_data
);

    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [TIME_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/pbst_alu.sv]
// Shared add/subtract unit: a <= b compare, or saturating a + b.
module pbst_alu
    import pbst_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  alu_op_t                        op,
    input  logic [TIME_BITS-1:0]           a,
    input  logic [((TIME_BITS > PT_W) ? TIME_BITS : PT_W)-1:0] b,
    output logic                           le,
    output logic [TIME_BITS-1:0]           res
);

    localparam int BW = (TIME_BITS > PT_W) ? TIME_BITS : PT_W;
    localparam int SW = BW + 1;

    logic [SW-1:0] a_ext;
    logic [SW-1:0] b_ext;
    logic [SW-1:0] r;
    logic          sat;

    assign a_ext = SW'(a);
    assign b_ext = SW'(b);

    // compare runs as b - a; the top bit is the borrow
    assign r   = (op == ALU_LE) ? (b_ext - a_ext) : (a_ext + b_ext);
    assign le  = ~r[SW-1];
    assign sat = |r[SW-1:TIME_BITS];
    assign res = sat ? {TIME_BITS{1'b1}} : r[TIME_BITS-1:0];

endmodule
